// ===== rtl/fbrf_pkg.sv =====
// ----------------------------------------------------------------------------
// fbrf_pkg
// Shared types and constants of the rectangle fill engine: frame geometry,
// command codes and the request descriptors passed between front and back.
// ----------------------------------------------------------------------------
package fbrf_pkg;

  // frame geometry limits
  localparam int MAX_LINE_PIXELS = 256;
  localparam int MAX_LINES       = 256;
  localparam int STORE_WORDS     = MAX_LINE_PIXELS * MAX_LINES;

  localparam int COL_W     = $clog2(MAX_LINE_PIXELS);
  localparam int ROW_W     = $clog2(MAX_LINES);
  localparam int COL_CNT_W = $clog2(MAX_LINE_PIXELS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_LINES + 1);
  localparam int ADDR_W    = $clog2(STORE_WORDS);
  localparam int PROD_W    = ROW_W + COL_CNT_W;

  // field widths
  localparam int CFG_W   = 9;
  localparam int CMD_W   = 2;
  localparam int COORD_W = 13;
  localparam int PIX_W   = 32;
  localparam int CLIP_W  = COORD_W + 2;

  // request queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic REG_LINE_PIXELS = 1'b0;
  localparam logic REG_LINE_COUNT  = 1'b1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd3;

  // work kinds seen by the back end
  typedef enum logic [1:0] {
    OP_FILL,
    OP_WRITE,
    OP_READ
  } op_t;

  // clipped request after the first front stage
  typedef struct packed {
    op_t                  op;
    logic                 hit;
    logic [COL_W-1:0]     x0;
    logic [ROW_W-1:0]     y0;
    logic [COL_CNT_W-1:0] w;
    logic [ROW_CNT_W-1:0] h;
    logic [COL_CNT_W-1:0] cols;
    logic [PIX_W-1:0]     color;
  } clip_t;

  // request descriptor held in the queue
  typedef struct packed {
    op_t                  op;
    logic                 hit;
    logic [ADDR_W-1:0]    addr;
    logic [COL_CNT_W-1:0] w;
    logic [ROW_CNT_W-1:0] h;
    logic [COL_CNT_W-1:0] cols;
    logic [PIX_W-1:0]     color;
  } task_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_DONE
  } back_state_t;

endpackage

// ===== rtl/fbrf_front.sv =====
// ----------------------------------------------------------------------------
// fbrf_front
// Holds the geometry registers, accepts requests, clips them against the
// active frame and turns them into start address plus extent for the queue.
// ----------------------------------------------------------------------------
module fbrf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fbrf_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          init_done,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fbrf_pkg::CMD_W-1:0]    cmd,
  input  logic signed [fbrf_pkg::COORD_W-1:0] x,
  input  logic signed [fbrf_pkg::COORD_W-1:0] y,
  input  logic signed [fbrf_pkg::COORD_W-1:0] rect_width,
  input  logic signed [fbrf_pkg::COORD_W-1:0] rect_height,
  input  logic [fbrf_pkg::PIX_W-1:0]    color,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fbrf_pkg::task_t               push_data
);

  logic [fbrf_pkg::CFG_W-1:0]     line_pixels;
  logic [fbrf_pkg::CFG_W-1:0]     line_count;
  logic [fbrf_pkg::COL_CNT_W-1:0] cols;
  logic [fbrf_pkg::ROW_CNT_W-1:0] rows;

  logic signed [fbrf_pkg::CLIP_W-1:0] xs, ys, ws, hs;
  logic signed [fbrf_pkg::CLIP_W-1:0] xc, yc, wc, hc;
  logic signed [fbrf_pkg::CLIP_W-1:0] cols_s, rows_s;
  logic                               pix_in_frame;

  fbrf_pkg::clip_t              clip;
  fbrf_pkg::clip_t              s1;
  logic                         s1_valid;
  logic [fbrf_pkg::PROD_W-1:0]  prod;

  // geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_pixels <= fbrf_pkg::CFG_W'(256);
      line_count  <= fbrf_pkg::CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbrf_pkg::REG_LINE_PIXELS: line_pixels <= cfg_data;
        fbrf_pkg::REG_LINE_COUNT:  line_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  // active frame size, clamped to the store
  always_comb begin
    cols = (32'(line_pixels) > fbrf_pkg::MAX_LINE_PIXELS)
         ? fbrf_pkg::COL_CNT_W'(fbrf_pkg::MAX_LINE_PIXELS)
         : fbrf_pkg::COL_CNT_W'(line_pixels);
    rows = (32'(line_count) > fbrf_pkg::MAX_LINES)
         ? fbrf_pkg::ROW_CNT_W'(fbrf_pkg::MAX_LINES)
         : fbrf_pkg::ROW_CNT_W'(line_count);
  end

  // rectangle clipping and pixel bounds check
  always_comb begin
    xs     = fbrf_pkg::CLIP_W'(x);
    ys     = fbrf_pkg::CLIP_W'(y);
    ws     = fbrf_pkg::CLIP_W'(rect_width);
    hs     = fbrf_pkg::CLIP_W'(rect_height);
    cols_s = fbrf_pkg::CLIP_W'({1'b0, cols});
    rows_s = fbrf_pkg::CLIP_W'({1'b0, rows});

    // negative origin shrinks the extent
    xc = (xs < 0) ? '0 : xs;
    wc = (xs < 0) ? ws + xs : ws;
    yc = (ys < 0) ? '0 : ys;
    hc = (ys < 0) ? hs + ys : hs;
    // far edge cut
    if (xc + wc > cols_s) wc = cols_s - xc;
    if (yc + hc > rows_s) hc = rows_s - yc;

    pix_in_frame = (xs >= 0) && (xs < cols_s) && (ys >= 0) && (ys < rows_s);

    clip.color = color;
    clip.cols  = cols;
    unique case (cmd)
      fbrf_pkg::CMD_CLEAR: begin
        clip.op  = fbrf_pkg::OP_FILL;
        clip.hit = (cols != '0) && (rows != '0);
        clip.x0  = '0;
        clip.y0  = '0;
        clip.w   = cols;
        clip.h   = rows;
      end
      fbrf_pkg::CMD_FILL: begin
        clip.op  = fbrf_pkg::OP_FILL;
        clip.hit = (wc > 0) && (hc > 0);
        clip.x0  = xc[fbrf_pkg::COL_W-1:0];
        clip.y0  = yc[fbrf_pkg::ROW_W-1:0];
        clip.w   = wc[fbrf_pkg::COL_CNT_W-1:0];
        clip.h   = hc[fbrf_pkg::ROW_CNT_W-1:0];
      end
      default: begin
        clip.op  = (cmd == fbrf_pkg::CMD_SET) ? fbrf_pkg::OP_WRITE : fbrf_pkg::OP_READ;
        clip.hit = pix_in_frame;
        clip.x0  = x[fbrf_pkg::COL_W-1:0];
        clip.y0  = y[fbrf_pkg::ROW_W-1:0];
        clip.w   = fbrf_pkg::COL_CNT_W'(1);
        clip.h   = fbrf_pkg::ROW_CNT_W'(1);
      end
    endcase
  end

  assign in_ready = init_done && (!s1_valid || push_ready);

  // clip stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= clip;
    end
  end

  // start address: line times stride plus column
  assign prod = fbrf_pkg::PROD_W'(s1.y0) * fbrf_pkg::PROD_W'(s1.cols);

  always_comb begin
    push_valid      = s1_valid;
    push_data.op    = s1.op;
    push_data.hit   = s1.hit;
    push_data.addr  = fbrf_pkg::ADDR_W'(prod) + fbrf_pkg::ADDR_W'(s1.x0);
    push_data.w     = s1.w;
    push_data.h     = s1.h;
    push_data.cols  = s1.cols;
    push_data.color = s1.color;
  end

endmodule

// ===== rtl/fbrf_queue.sv =====
// ----------------------------------------------------------------------------
// fbrf_queue
// Short request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fbrf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  fbrf_pkg::task_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fbrf_pkg::task_t pop_data
);

  fbrf_pkg::task_t                 entries [fbrf_pkg::QUEUE_DEPTH];
  logic [fbrf_pkg::QPTR_W-1:0]     wr_ptr;
  logic [fbrf_pkg::QPTR_W-1:0]     rd_ptr;
  logic [fbrf_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = (count != fbrf_pkg::QCNT_W'(fbrf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == fbrf_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == fbrf_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/fbrf_back.sv =====
// ----------------------------------------------------------------------------
// fbrf_back
// Owns the frame store: clears it after reset, then carries out queued
// requests one pixel per cycle and presents one result per request.
// ----------------------------------------------------------------------------
module fbrf_back (
  input  logic                        clk,
  input  logic                        rst,
  output logic                        init_done,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  fbrf_pkg::task_t             q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbrf_pkg::PIX_W-1:0]  pixel_value,
  output logic                        in_range
);

  fbrf_pkg::back_state_t state, state_next;

  logic [fbrf_pkg::PIX_W-1:0]     store [fbrf_pkg::STORE_WORDS];
  logic [fbrf_pkg::PIX_W-1:0]     rd_data;
  logic                           mem_we;
  logic [fbrf_pkg::ADDR_W-1:0]    mem_wa;
  logic [fbrf_pkg::PIX_W-1:0]     mem_wd;

  logic [fbrf_pkg::ADDR_W-1:0]    init_addr;
  logic [fbrf_pkg::ADDR_W-1:0]    addr;
  logic [fbrf_pkg::ADDR_W-1:0]    row_base;
  logic [fbrf_pkg::ADDR_W-1:0]    next_row;
  logic [fbrf_pkg::COL_W-1:0]     col;
  logic [fbrf_pkg::ROW_W-1:0]     row;
  logic [fbrf_pkg::COL_CNT_W-1:0] w;
  logic [fbrf_pkg::ROW_CNT_W-1:0] h;
  logic [fbrf_pkg::COL_CNT_W-1:0] cols;
  logic [fbrf_pkg::PIX_W-1:0]     color;
  logic [fbrf_pkg::PIX_W-1:0]     res_value;
  logic                           res_hit;

  logic init_last;
  logic col_end;
  logic row_end;
  logic out_load;

  assign init_last = (init_addr == fbrf_pkg::ADDR_W'(fbrf_pkg::STORE_WORDS - 1));
  assign col_end   = ({1'b0, col} == fbrf_pkg::COL_CNT_W'(w - 1'b1));
  assign row_end   = ({1'b0, row} == fbrf_pkg::ROW_CNT_W'(h - 1'b1));
  assign next_row  = row_base + fbrf_pkg::ADDR_W'(cols);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fbrf_pkg::ST_INIT: begin
        if (init_last) state_next = fbrf_pkg::ST_IDLE;
      end
      fbrf_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_data.hit && q_data.op == fbrf_pkg::OP_FILL) begin
            state_next = fbrf_pkg::ST_FILL;
          end else if (q_data.hit && q_data.op == fbrf_pkg::OP_READ) begin
            state_next = fbrf_pkg::ST_READ;
          end else begin
            state_next = fbrf_pkg::ST_DONE;
          end
        end
      end
      fbrf_pkg::ST_FILL: begin
        if (col_end && row_end) state_next = fbrf_pkg::ST_DONE;
      end
      fbrf_pkg::ST_READ: begin
        state_next = fbrf_pkg::ST_DONE;
      end
      fbrf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) state_next = fbrf_pkg::ST_IDLE;
      end
      default: state_next = fbrf_pkg::ST_INIT;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    init_done = (state != fbrf_pkg::ST_INIT);
    q_pop     = (state == fbrf_pkg::ST_IDLE) && q_valid;
    out_load  = (state == fbrf_pkg::ST_DONE) && (!out_valid || out_ready);
    mem_we    = 1'b0;
    mem_wa    = addr;
    mem_wd    = color;
    unique case (state)
      fbrf_pkg::ST_INIT: begin
        mem_we = 1'b1;
        mem_wa = init_addr;
        mem_wd = '0;
      end
      fbrf_pkg::ST_IDLE: begin
        mem_we = q_valid && q_data.hit && (q_data.op == fbrf_pkg::OP_WRITE);
        mem_wa = q_data.addr;
        mem_wd = q_data.color;
      end
      fbrf_pkg::ST_FILL: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbrf_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    rd_data <= store[q_data.addr];
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (state == fbrf_pkg::ST_INIT) begin
      init_addr <= init_addr + 1'b1;
    end
  end

  // request walk: address, column and line counters
  always_ff @(posedge clk) begin
    if (q_pop) begin
      addr      <= q_data.addr;
      row_base  <= q_data.addr;
      col       <= '0;
      row       <= '0;
      w         <= q_data.w;
      h         <= q_data.h;
      cols      <= q_data.cols;
      color     <= q_data.color;
      res_hit   <= q_data.hit;
      res_value <= '0;
    end else if (state == fbrf_pkg::ST_FILL) begin
      if (col_end) begin
        col      <= '0;
        row      <= row + 1'b1;
        row_base <= next_row;
        addr     <= next_row;
      end else begin
        col  <= col + 1'b1;
        addr <= addr + 1'b1;
      end
    end else if (state == fbrf_pkg::ST_READ) begin
      res_value <= rd_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pixel_value <= res_value;
      in_range    <= res_hit;
    end
  end

endmodule

// ===== rtl/framebuffer_rect_fill_engine.sv =====
// ----------------------------------------------------------------------------
// framebuffer_rect_fill_engine
// Solid fill engine over a 32-bit-per-pixel frame store with clear, rectangle
// fill, pixel set and pixel get requests, one result per request.
// The back end writes one pixel per cycle through the single store write
// port while filling, and takes no new request until the last is done.
// Reset: a clearing pass zeroes all 65536 store words; in_ready stays low
// until it ends, geometry writes are taken throughout.
// ----------------------------------------------------------------------------
module framebuffer_rect_fill_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [fbrf_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fbrf_pkg::CMD_W-1:0]          cmd,
  input  logic signed [fbrf_pkg::COORD_W-1:0] x,
  input  logic signed [fbrf_pkg::COORD_W-1:0] y,
  input  logic signed [fbrf_pkg::COORD_W-1:0] rect_width,
  input  logic signed [fbrf_pkg::COORD_W-1:0] rect_height,
  input  logic [fbrf_pkg::PIX_W-1:0]          color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fbrf_pkg::PIX_W-1:0]          pixel_value,
  output logic                                in_range
);

  logic            init_done;
  logic            push_valid;
  logic            push_ready;
  fbrf_pkg::task_t push_data;
  logic            q_valid;
  logic            q_pop;
  fbrf_pkg::task_t q_data;

  // request intake and clipping
  fbrf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .init_done   (init_done),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .x           (x),
    .y           (y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  // decoupling queue
  fbrf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // frame store and pixel walk
  fbrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .init_done   (init_done),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_value (pixel_value),
    .in_range    (in_range)
  );

endmodule
